// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off while in reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pmst_pkg.sv =====
package pmst_pkg;

  localparam int MAX_NODES   = 64;
  localparam int WEIGHT_BITS = 20;

  // fixed field widths of the beats
  localparam int EDGE_FIELD_BITS = 20;
  localparam int VTX_FIELD_BITS  = 6;
  localparam int CFG_BITS        = 7;

  localparam int NODE_BITS = $clog2(MAX_NODES);
  localparam int CNT_BITS  = $clog2(MAX_NODES + 1);
  localparam int POS_BITS  = 2 * NODE_BITS;
  localparam int KEY_BITS  = WEIGHT_BITS + 1;
  localparam int PAR_BITS  = 7;

  localparam logic [PAR_BITS-1:0] PARENT_NONE = '1;
  localparam logic [KEY_BITS-1:0] KEY_INF     = {1'b1, {WEIGHT_BITS{1'b0}}};

  typedef struct packed {
    logic [EDGE_FIELD_BITS-1:0] edge_weight;
    logic                       last_entry;
  } pmst_in_t;

  typedef struct packed {
    logic [VTX_FIELD_BITS-1:0]  child_vertex;
    logic [VTX_FIELD_BITS-1:0]  parent_vertex;
    logic [EDGE_FIELD_BITS-1:0] tree_weight;
    logic                       unreached;
    logic                       last_edge;
  } pmst_out_t;

  // per-vertex entry of the vertex RAM
  typedef struct packed {
    logic                in_tree;
    logic [PAR_BITS-1:0] parent;
    logic [KEY_BITS-1:0] key;
  } pmst_vtx_t;

  // load address tracker status towards the sequencer
  typedef struct packed {
    logic                 busy;
    logic [CNT_BITS-1:0]  nodes;
    logic [NODE_BITS-1:0] row;
    logic [NODE_BITS-1:0] col;
  } pmst_load_t;

endpackage

// ===== rtl/pmst_ram.sv =====
module pmst_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pmst_load_addr.sv =====
module pmst_load_addr import pmst_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                step,
  input  logic                last,
  output pmst_load_t          load
);

  localparam int DIV_CNT_BITS = $clog2(POS_BITS);

  logic [CNT_BITS-1:0]     nodes;
  logic [POS_BITS-1:0]     pos;
  logic [NODE_BITS-1:0]    row;
  logic [NODE_BITS-1:0]    col;
  logic                    over;
  logic                    div_busy;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [POS_BITS-1:0]     dsh;
  logic [CNT_BITS-1:0]     rem;
  logic [POS_BITS-1:0]     quo;

  logic [CNT_BITS-1:0] nodes_cfg;
  logic [CNT_BITS-1:0] nodes_m1;
  logic [CNT_BITS:0]   remsh;
  logic                ge;
  logic [CNT_BITS-1:0] rem_new;
  logic [POS_BITS-1:0] quo_new;
  logic                div_done;
  logic                row_end;
  logic                col_end;
  logic [POS_BITS-1:0] pos_inc;

  always_comb begin
    if (cfg_data == '0) begin
      nodes_cfg = CNT_BITS'(1);
    end else if (cfg_data > CFG_BITS'(MAX_NODES)) begin
      nodes_cfg = CNT_BITS'(MAX_NODES);
    end else begin
      nodes_cfg = CNT_BITS'(cfg_data);
    end
  end

  // restoring divide of the load position by the vertex count, one bit a cycle
  assign remsh    = {rem, dsh[POS_BITS-1]};
  assign ge       = remsh >= (CNT_BITS + 1)'(nodes);
  assign rem_new  = ge ? CNT_BITS'(remsh - (CNT_BITS + 1)'(nodes)) : remsh[CNT_BITS-1:0];
  assign quo_new  = {quo[POS_BITS-2:0], ge};
  assign div_done = div_cnt == DIV_CNT_BITS'(POS_BITS - 1);

  assign nodes_m1 = nodes - CNT_BITS'(1);
  assign row_end  = CNT_BITS'(row) == nodes_m1;
  assign col_end  = CNT_BITS'(col) == nodes_m1;
  // a position left beyond the matrix counts from zero
  assign pos_inc  = (over ? '0 : pos) + POS_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes    <= CNT_BITS'(MAX_NODES);
      pos      <= '0;
      row      <= '0;
      col      <= '0;
      over     <= 1'b0;
      div_busy <= 1'b0;
    end else if (cfg_we) begin
      nodes    <= nodes_cfg;
      div_busy <= 1'b1;
      div_cnt  <= '0;
      dsh      <= pos;
      rem      <= '0;
      quo      <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + DIV_CNT_BITS'(1);
      dsh     <= {dsh[POS_BITS-2:0], 1'b0};
      rem     <= rem_new;
      quo     <= quo_new;
      if (div_done) begin
        div_busy <= 1'b0;
        // pos itself is kept: a later, larger count may bring it back in range
        if (quo_new < POS_BITS'(nodes)) begin
          row  <= NODE_BITS'(quo_new);
          col  <= NODE_BITS'(rem_new);
          over <= 1'b0;
        end else begin
          row  <= '0;
          col  <= '0;
          over <= 1'b1;
        end
      end
    end else if (step) begin
      over <= 1'b0;
      if (last || (row_end && col_end)) begin
        pos <= '0;
        row <= '0;
        col <= '0;
      end else begin
        pos <= pos_inc;
        if (col_end) begin
          col <= '0;
          row <= row + NODE_BITS'(1);
        end else begin
          col <= col + NODE_BITS'(1);
        end
      end
    end
  end

  assign load.busy  = div_busy;
  assign load.nodes = nodes;
  assign load.row   = row;
  assign load.col   = col;

endmodule

// ===== rtl/prim_mst_dense_matrix_core.sv =====
// Minimum spanning tree over a dense weight matrix, grown from vertex 0. Matrix entries
// load one per cycle while busy is low, in row-major order (zero weight = no edge). The
// entry with last_entry set starts the search unless the vertex count is one; busy then
// stays high for vertex-table setup and (n-1) rounds, each a pass over the n vertices,
// one vertex RAM entry and one weight RAM word per cycle, a drain step and, but in the
// final round, a step to the next pick; then the results are read. The n-1 results
// (vertex 1 upwards) come on consecutive cycles, each marked by strobe for one cycle and
// not stallable; the last two appear just after busy drops. A cfg_we write of the vertex
// count raises busy while the load position is re-mapped onto the new row length.
module prim_mst_dense_matrix_core import pmst_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pmst_in_t            item,
  output logic                busy,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data,
  output pmst_out_t           result,
  output logic                strobe
);

  localparam int VTX_BITS = $bits(pmst_vtx_t);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_PASS  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_NEXT  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;

  pmst_load_t load;
  logic       accept;

  logic [NODE_BITS-1:0] idx;
  logic [NODE_BITS-1:0] rd_v;
  logic [NODE_BITS-1:0] last_v;
  logic [NODE_BITS-1:0] pick;
  logic [NODE_BITS-1:0] rounds;
  logic                 p_valid;
  logic                 e_valid;
  logic                 found;
  logic [KEY_BITS-1:0]  best_key;
  logic [NODE_BITS-1:0] best_idx;

  logic [WEIGHT_BITS-1:0] w_rd;
  logic [VTX_BITS-1:0]    v_rd_raw;
  pmst_vtx_t              v_rd;
  pmst_vtx_t              st_new;
  pmst_vtx_t              init_st;
  pmst_vtx_t              v_wdata;
  logic                   v_we;
  logic [NODE_BITS-1:0]   v_waddr;
  logic                   cand;
  pmst_out_t              result_next;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE) || load.busy;

  pmst_load_addr u_load (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (accept),
    .last     (item.last_entry),
    .load     (load)
  );

  pmst_ram #(
    .ADDR_W (POS_BITS),
    .DATA_W (WEIGHT_BITS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (accept),
    .waddr ({load.row, load.col}),
    .wdata (WEIGHT_BITS'(item.edge_weight)),
    .raddr ({pick, idx}),
    .rdata (w_rd)
  );

  assign init_st.in_tree = 1'b0;
  assign init_st.parent  = PARENT_NONE;
  assign init_st.key     = (idx == '0) ? '0 : KEY_INF;

  assign v_we    = (state == S_INIT) || p_valid;
  assign v_waddr = p_valid ? rd_v : idx;
  assign v_wdata = p_valid ? st_new : init_st;

  pmst_ram #(
    .ADDR_W (NODE_BITS),
    .DATA_W (VTX_BITS)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (idx),
    .rdata (v_rd_raw)
  );

  assign v_rd = v_rd_raw;

  // relax one vertex against the picked row and track the next pick in the same pass
  always_comb begin
    st_new = v_rd;
    if (rd_v == pick) begin
      st_new.in_tree = 1'b1;
    end else if (w_rd != '0 && !v_rd.in_tree && {1'b0, w_rd} < v_rd.key) begin
      st_new.parent = PAR_BITS'(pick);
      st_new.key    = {1'b0, w_rd};
    end
  end

  assign cand = !st_new.in_tree && (!found || st_new.key < best_key);

  always_comb begin
    result_next.child_vertex = VTX_FIELD_BITS'(rd_v);
    result_next.unreached    = v_rd.parent == PARENT_NONE;
    result_next.parent_vertex = result_next.unreached ? '0 : VTX_FIELD_BITS'(v_rd.parent);
    result_next.tree_weight   = result_next.unreached ? '0 :
                                EDGE_FIELD_BITS'(v_rd.key[WEIGHT_BITS-1:0]);
    result_next.last_edge    = rd_v == last_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      p_valid <= 1'b0;
      e_valid <= 1'b0;
      strobe  <= 1'b0;
      found   <= 1'b0;
    end else begin
      p_valid <= state == S_PASS;
      e_valid <= state == S_EMIT;
      strobe  <= e_valid;
      if (p_valid && cand) begin
        found    <= 1'b1;
        best_key <= st_new.key;
        best_idx <= rd_v;
      end
      case (state)
        S_IDLE: begin
          if (accept && item.last_entry && load.nodes != CNT_BITS'(1)) begin
            idx    <= '0;
            last_v <= NODE_BITS'(load.nodes - CNT_BITS'(1));
            state  <= S_INIT;
          end
        end
        S_INIT: begin
          if (idx == last_v) begin
            idx    <= '0;
            pick   <= '0;
            found  <= 1'b0;
            rounds <= last_v;
            state  <= S_PASS;
          end else begin
            idx <= idx + NODE_BITS'(1);
          end
        end
        S_PASS: begin
          if (idx == last_v) begin
            idx   <= '0;
            state <= S_DRAIN;
          end else begin
            idx <= idx + NODE_BITS'(1);
          end
        end
        S_DRAIN: begin
          // last vertex of the pass is written back this cycle
          if (rounds == NODE_BITS'(1)) begin
            idx   <= NODE_BITS'(1);
            state <= S_EMIT;
          end else begin
            rounds <= rounds - NODE_BITS'(1);
            state  <= S_NEXT;
          end
        end
        S_NEXT: begin
          pick  <= best_idx;
          found <= 1'b0;
          state <= S_PASS;
        end
        S_EMIT: begin
          if (idx == last_v) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + NODE_BITS'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_v <= idx;
    if (e_valid) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/pmst_checker.sv =====
`include "assert_macros.svh"

module pmst_checker import pmst_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      busy,
  input logic      cfg_we,
  input pmst_out_t result,
  input logic      strobe
);

  `CHK_IMPLY(a_child_nonzero, clk, rst, strobe, result.child_vertex != '0, "result beat for root vertex")
  `CHK_IMPLY(a_unreached_clean, clk, rst, strobe && result.unreached, result.parent_vertex == '0 && result.tree_weight == '0, "unreached vertex carries parent or weight")
  `CHK_NEXT(a_burst_order, clk, rst, strobe && !result.last_edge, strobe && result.child_vertex == $past(result.child_vertex) + 6'd1, "result beats not consecutive")
  `CHK_NEXT(a_cfg_busy, clk, rst, cfg_we, busy, "no busy after node count write")

endmodule

bind prim_mst_dense_matrix_core pmst_checker u_pmst_checker (.*);

// ===== tb/sv/prim_mst_dense_matrix_core_checker.sv =====
`timescale 1ns / 100ps
module prim_mst_dense_matrix_core_checker import pmst_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pmst_in_t            item,
  input  logic                busy,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  pmst_out_t           result,
  input  logic                strobe,
  output int                  errors,
  output int                  pending
);

  logic [WEIGHT_BITS-1:0] weights [MAX_NODES*MAX_NODES];
  logic [KEY_BITS-1:0]    key     [MAX_NODES];
  logic [PAR_BITS-1:0]    parent  [MAX_NODES];
  bit                     joined  [MAX_NODES];
  logic [CFG_BITS-1:0]    nodes_reg;
  int                     fill_pos;
  pmst_out_t              edges_due [$];

  initial begin
    foreach (weights[i]) weights[i] = '0;
  end

  function automatic int live_nodes();
    if (nodes_reg == '0) return 1;
    if (nodes_reg > MAX_NODES) return MAX_NODES;
    return int'(nodes_reg);
  endfunction

  task automatic grow_from_root(input int n);
    int                     pick;
    bit                     found;
    bit                     none;
    logic [WEIGHT_BITS-1:0] w;
    pmst_out_t              e;
    for (int v = 0; v < MAX_NODES; v++) begin
      key[v]    = KEY_INF;
      joined[v] = 1'b0;
      parent[v] = PARENT_NONE;
    end
    key[0] = '0;
    for (int r = 0; r + 1 < n; r++) begin
      pick  = 0;
      found = 1'b0;
      // lowest key outside the tree, first index wins a tie
      for (int v = 0; v < n; v++) begin
        if (!joined[v] && (!found || key[v] < key[pick])) begin
          pick  = v;
          found = 1'b1;
        end
      end
      joined[pick] = 1'b1;
      // an unreached pick still relaxes its row
      for (int v = 0; v < n; v++) begin
        w = weights[pick * MAX_NODES + v];
        if (w != '0 && !joined[v] && {1'b0, w} < key[v]) begin
          parent[v] = PAR_BITS'(pick);
          key[v]    = {1'b0, w};
        end
      end
    end
    for (int v = 1; v < n; v++) begin
      none            = (parent[v] == PARENT_NONE);
      e.child_vertex  = VTX_FIELD_BITS'(v);
      e.parent_vertex = none ? '0 : parent[v][VTX_FIELD_BITS-1:0];
      e.tree_weight   = none ? '0 : key[v][EDGE_FIELD_BITS-1:0];
      e.unreached     = none;
      e.last_edge     = (v + 1 == n);
      edges_due       = {edges_due, e};
    end
  endtask

  task automatic take_entry(input pmst_in_t beat);
    int n;
    int cells;
    n     = live_nodes();
    cells = n * n;
    if (fill_pos >= cells) fill_pos = 0;
    weights[(fill_pos / n) * MAX_NODES + fill_pos % n] = beat.edge_weight[WEIGHT_BITS-1:0];
    fill_pos++;
    if (fill_pos >= cells) fill_pos = 0;
    if (beat.last_entry) begin
      fill_pos = 0;
      grow_from_root(n);
    end
  endtask

  task automatic check_edge(input pmst_out_t got);
    pmst_out_t want;
    if (edges_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result beat with nothing due: child %0d parent %0d weight %0h",
                 $time, got.child_vertex, got.parent_vertex, got.tree_weight);
      return;
    end
    want = edges_due.pop_front();
    if (got.child_vertex !== want.child_vertex || got.parent_vertex !== want.parent_vertex ||
        got.tree_weight !== want.tree_weight || got.unreached !== want.unreached ||
        got.last_edge !== want.last_edge) begin
      errors++;
      if (errors <= 10)
        $display("%0t: tree edge mismatch (exp/got) child %0d/%0d parent %0d/%0d", $time,
                 want.child_vertex, got.child_vertex, want.parent_vertex, got.parent_vertex,
                 " weight %0h/%0h unreached %0b/%0b last %0b/%0b",
                 want.tree_weight, got.tree_weight, want.unreached, got.unreached,
                 want.last_edge, got.last_edge);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      nodes_reg = 7'd64;
      fill_pos  = 0;
      edges_due.delete();
    end else begin
      if (strobe) check_edge(result);
      if (cfg_we) nodes_reg = cfg_data;
      if (start && !busy) take_entry(item);
    end
    pending = edges_due.size();
  end

endmodule

// ===== tb/sv/prim_mst_dense_matrix_core_tb.sv =====
`timescale 1ns / 100ps
module prim_mst_dense_matrix_core_tb;
  import pmst_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 32;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   cfg_we;
  logic                   strobe;
  logic [CFG_BITS-1:0]    cfg_data;
  pmst_in_t               item;
  pmst_out_t              result;
  int                     errors;
  int                     pending;
  int                     idle_pct;
  int                     beats_sent;
  int                     load_pos;
  int                     span;
  int                     cycles = 0;
  bit                     filled [MAX_NODES*MAX_NODES];
  logic [WEIGHT_BITS-1:0] pattern [$];

  prim_mst_dense_matrix_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result),
    .strobe   (strobe)
  );

  prim_mst_dense_matrix_core_checker tree_mon (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result),
    .strobe   (strobe),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int eff_nodes(input logic [CFG_BITS-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_NODES) return MAX_NODES;
    return int'(v);
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] rand_weight(input int zero_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < zero_pct) return '0;
    if (pick < zero_pct + (100 - zero_pct) / 3) return WEIGHT_BITS'($urandom_range(1, 4));
    if (pick > 92) return '1;
    return WEIGHT_BITS'($urandom_range(1, (1 << WEIGHT_BITS) - 1));
  endfunction

  // every cell of the active square written, bar the one the next beat lands on
  function automatic bit square_ready();
    int p;
    int hole;
    p    = (load_pos >= span * span) ? 0 : load_pos;
    hole = (p / span) * MAX_NODES + p % span;
    for (int r = 0; r < span; r++)
      for (int c = 0; c < span; c++)
        if (!filled[r * MAX_NODES + c] && (r * MAX_NODES + c) != hole) return 1'b0;
    return 1'b1;
  endfunction

  // entered and left at a falling edge; start stays high on return
  task automatic send_entry(input logic [WEIGHT_BITS-1:0] w, input logic last);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item  <= '{edge_weight: w, last_entry: last};
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
    if (load_pos >= span * span) load_pos = 0;
    filled[(load_pos / span) * MAX_NODES + load_pos % span] = 1'b1;
    load_pos++;
    if (load_pos >= span * span || last) load_pos = 0;
    beats_sent++;
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(negedge clk);
  endtask

  task automatic play_pattern(input bit close);
    foreach (pattern[i]) send_entry(pattern[i], close && i == pattern.size() - 1);
    release_start();
  endtask

  task automatic load_tree(input int count, input int zero_pct);
    for (int i = 1; i < count; i++) send_entry(rand_weight(zero_pct), 1'b0);
    // never let the search read a cell that was not loaded
    while (!square_ready()) send_entry(rand_weight(zero_pct), 1'b0);
    send_entry(rand_weight(zero_pct), 1'b1);
    release_start();
  endtask

  task automatic noise_load(input int count);
    for (int i = 0; i < count; i++) send_entry(rand_weight(30), 1'b0);
    release_start();
  endtask

  task automatic set_nodes(input logic [CFG_BITS-1:0] v);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    span = eff_nodes(v);
  endtask

  function automatic logic [CFG_BITS-1:0] pick_nodes();
    int r;
    r = $urandom_range(99);
    if (r < 70) return CFG_BITS'($urandom_range(2, 6));
    if (r < 85) return CFG_BITS'($urandom_range(7, 12));
    if (r < 90) return CFG_BITS'($urandom_range(13, 16));
    if (r < 94) return '0;
    if (r < 97) return CFG_BITS'(1);
    return $urandom_range(1) ? '1 : CFG_BITS'(MAX_NODES + 1);
  endfunction

  task automatic run_phase(input int pct, input int quota);
    int stop_at;
    int kind;
    int zp;
    idle_pct = pct;
    stop_at  = beats_sent + quota;
    set_nodes(pick_nodes());
    while (beats_sent < stop_at) begin
      kind = $urandom_range(99);
      zp   = $urandom_range(1) ? 20 : 70;
      if (kind < 8) set_nodes(pick_nodes());
      else if (span == MAX_NODES) noise_load($urandom_range(1, 40));
      else if (kind < 55) load_tree(span * span, zp);
      else if (kind < 70) load_tree($urandom_range(1, span * span), zp);
      else if (kind < 80) load_tree(span * span + $urandom_range(1, 2 * span), zp);
      else noise_load($urandom_range(1, span * span));
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    item       = '0;
    idle_pct   = 0;
    beats_sent = 0;
    load_pos   = 0;
    span       = MAX_NODES;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // two vertices joined by the heaviest weight
    set_nodes(CFG_BITS'(2));
    pattern = '{20'd0, 20'hFFFFF, 20'hFFFFF, 20'd0};
    play_pattern(1'b1);
    // lone vertex, then a zero count that behaves as one
    set_nodes(CFG_BITS'(1));
    pattern = '{20'd9};
    play_pattern(1'b1);
    set_nodes('0);
    pattern = '{20'h5A5A5};
    play_pattern(1'b1);
    // equal keys, lowest index first; rows not mirrored
    set_nodes(CFG_BITS'(3));
    pattern = '{20'd0, 20'd5, 20'd5, 20'd5, 20'd0, 20'd1, 20'd9, 20'd1, 20'd0};
    play_pattern(1'b1);
    // vertex 1 never reached but still relaxes vertex 2
    pattern = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd7, 20'd0, 20'd7, 20'd0};
    play_pattern(1'b1);
    // early last beat keeps the rest of the previous matrix
    pattern = '{20'd0, 20'd3};
    play_pattern(1'b1);
    // oversized count, then a part load that the next count write re-maps
    set_nodes('1);
    pattern = '{20'd1, 20'd2, 20'd3, 20'd4, 20'd5};
    play_pattern(1'b0);

    run_phase(0, 140);
    run_phase(65, 140);
    run_phase(21, 140);

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pmst_pkg.sv
rtl/pmst_ram.sv
rtl/pmst_load_addr.sv
rtl/prim_mst_dense_matrix_core.sv
rtl/pmst_checker.sv
tb/sv/prim_mst_dense_matrix_core_checker.sv
tb/sv/prim_mst_dense_matrix_core_tb.sv
